// File: hdl/dre_pkg.sv
`default_nettype none

package dre_pkg;

  // Width of raw bytes, deltas, run counts and code bytes.
  localparam int unsigned ByteW = 8;

  // Default longest run.
  localparam int unsigned MaxRunDefault = 255;

  // Depth of the run record queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // One closed run: its length and its delta value.
  typedef struct packed {
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] val;
  } run_t;

  // One queue entry. The first run is always emitted; the second only when
  // two_runs is set. last marks the record that ends the stream.
  typedef struct packed {
    run_t run_a;
    run_t run_b;
    logic two_runs;
    logic last;
  } rec_t;

endpackage

`default_nettype wire

// File: hdl/dre_front.sv
`default_nettype none

module dre_front #(
  parameter int unsigned MAX_RUN = dre_pkg::MaxRunDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [dre_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                      end_of_stream_i,
  output      logic                      rec_push_o,
  output      dre_pkg::rec_t             rec_o
);
  import dre_pkg::*;

  localparam logic [ByteW-1:0] MaxRunW = ByteW'(MAX_RUN);
  localparam logic [ByteW-1:0] OneW    = ByteW'(1);

  logic [ByteW-1:0] prior_q, prior_d;
  logic [ByteW-1:0] delta_q, delta_d;
  logic [ByteW-1:0] len_q,   len_d;

  logic [ByteW-1:0] diff;
  logic             closed;
  logic [ByteW-1:0] run_val;
  logic [ByteW-1:0] run_len;
  run_t             closed_run;
  run_t             open_run;

  // Classify the beat: extend the open run, start one, or close it.
  always_comb begin
    diff       = data_byte_i - prior_q;
    closed     = 1'b0;
    closed_run = '{len: len_q, val: delta_q};
    run_val    = diff;
    run_len    = OneW;
    if (len_q == '0) begin
      run_len = OneW;
    end else if (diff == delta_q && len_q < MaxRunW) begin
      run_val = delta_q;
      run_len = len_q + OneW;
    end else begin
      closed = 1'b1;
    end
    open_run = '{len: run_len, val: run_val};
  end

  // Build the queue record for closed and flushed runs.
  always_comb begin
    rec_push_o = accept_i && (closed || end_of_stream_i);
    rec_o.last = end_of_stream_i;
    rec_o.two_runs = closed && end_of_stream_i;
    rec_o.run_b = open_run;
    rec_o.run_a = closed ? closed_run : open_run;
  end

  // Next state; the end of a stream returns everything to reset.
  always_comb begin
    prior_d = prior_q;
    delta_d = delta_q;
    len_d   = len_q;
    if (accept_i) begin
      if (end_of_stream_i) begin
        prior_d = '0;
        delta_d = '0;
        len_d   = '0;
      end else begin
        prior_d = data_byte_i;
        delta_d = run_val;
        len_d   = run_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      delta_q <= '0;
      len_q   <= '0;
    end else begin
      prior_q <= prior_d;
      delta_q <= delta_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dre_queue.sv
`default_nettype none

module dre_queue #(
  parameter int unsigned DEPTH = dre_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dre_pkg::rec_t rec_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          empty_o,
  output      dre_pkg::rec_t rec_o
);
  import dre_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  rec_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dre_back.sv
`default_nettype none

module dre_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rec_empty_i,
  input  wire dre_pkg::rec_t             rec_i,
  output      logic                      rec_pop_o,
  output      logic                      empty_o,
  input  wire logic                      pop_i,
  output      logic [dre_pkg::ByteW-1:0] code_byte_o,
  output      logic                      code_last_o
);
  import dre_pkg::*;

  logic             phase_q, phase_d;
  logic [1:0]       pos_q, pos_d;
  logic             out_vld_q, out_vld_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;

  run_t             cur;
  logic             single;
  logic [1:0]       final_pos;
  logic             end_run;
  logic             end_rec;
  logic             step;
  logic [ByteW-1:0] cur_byte;

  // Pick the byte of the current run at the current position.
  always_comb begin
    cur       = phase_q ? rec_i.run_b : rec_i.run_a;
    single    = (cur.len == ByteW'(1));
    final_pos = single ? ((cur.val == '0) ? 2'd1 : 2'd0) : 2'd2;
    case (pos_q)
      2'd0:    cur_byte = (single && cur.val != '0) ? cur.val : '0;
      2'd1:    cur_byte = single ? '0 : cur.len;
      default: cur_byte = cur.val;
    endcase
    end_run   = (pos_q == final_pos);
    end_rec   = end_run && (phase_q || !rec_i.two_runs);
    step      = !rec_empty_i && (!out_vld_q || pop_i);
    rec_pop_o = step && end_rec;
  end

  // Walk through positions and runs; load the output register.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    out_vld_d = out_vld_q && !pop_i;
    byte_d    = byte_q;
    last_d    = last_q;
    if (step) begin
      out_vld_d = 1'b1;
      byte_d    = cur_byte;
      last_d    = end_rec && rec_i.last;
      if (end_run) begin
        pos_d   = '0;
        phase_d = !end_rec;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty_o     = !out_vld_q;
  assign code_byte_o = byte_q;
  assign code_last_o = last_q;

endmodule

`default_nettype wire

// File: hdl/delta_rle_byte_encoder.sv
`default_nettype none

// Delta and run-length byte encoder. Each input beat carries one raw byte;
// the front stage forms its delta to the previous byte (the first byte of a
// stream against zero), gathers equal deltas into runs of up to MAX_RUN and
// queues each closed run as a record. The back stage expands records into
// code bytes: a lone nonzero delta as itself, a lone zero as 00 00, a longer
// run as 00, count, value. The beat flagged end_of_stream flushes the open
// run, sets code_last on the final code byte and clears all state. The
// front takes one beat per cycle while the record queue has room; the back
// emits one code byte per cycle through its output register while records
// are waiting and that register is empty or being popped. A record is
// written to the queue when the beat that closes its run is accepted; with
// the back idle, its first code byte is then loaded into the output
// register.
module delta_rle_byte_encoder #(
  parameter int unsigned MAX_RUN = dre_pkg::MaxRunDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output      logic                      full,
  input  wire logic [dre_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                      end_of_stream_i,
  output      logic                      empty,
  input  wire logic                      pop,
  output      logic [dre_pkg::ByteW-1:0] code_byte_o,
  output      logic                      code_last_o
);
  import dre_pkg::*;

  logic accept;
  logic rec_push;
  logic rec_pop;
  logic rec_empty;
  rec_t rec_in;
  rec_t rec_out;

  // A beat is taken whenever push is high and the record queue has room.
  assign accept = push && !full;

  dre_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .rec_push_o     (rec_push),
    .rec_o          (rec_in)
  );

  dre_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .rec_i  (rec_in),
    .full_o (full),
    .pop_i  (rec_pop),
    .empty_o(rec_empty),
    .rec_o  (rec_out)
  );

  dre_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_empty_i(rec_empty),
    .rec_i      (rec_out),
    .rec_pop_o  (rec_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .code_byte_o(code_byte_o),
    .code_last_o(code_last_o)
  );

endmodule

`default_nettype wire

// File: test/tb_delta_rle_byte_encoder.sv
`timescale 1ns / 1ps

module tb_delta_rle_byte_encoder;

  import dre_pkg::*;

  localparam int unsigned MAX_RUN = MaxRunDefault;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 85;

  // One expected code byte with its end marker.
  typedef struct packed {
    logic [ByteW-1:0] code;
    logic             last;
  } code_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [ByteW-1:0] data_byte = '0;
  logic             end_of_stream = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [ByteW-1:0] code_byte;
  logic             code_last;

  // Expected code bytes, oldest first.
  code_beat_t exp_codes[$];

  // Encoder state as the stream so far implies it.
  logic [ByteW-1:0] last_raw = '0;
  logic [ByteW-1:0] open_delta = '0;
  logic [ByteW-1:0] open_len = '0;

  int next_gap = 0;
  int pop_wait = 0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int codes_seen = 0;
  int streams_done = 0;
  int full_runs = 0;
  int escaped_zeros = 0;

  delta_rle_byte_encoder #(
    .MAX_RUN(MAX_RUN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte),
    .end_of_stream_i(end_of_stream),
    .empty          (empty),
    .pop            (pop),
    .code_byte_o    (code_byte),
    .code_last_o    (code_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, some medium, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // Queue the code bytes of one closed run; mark the final one if asked.
  task automatic emit_run_codes(input logic [ByteW-1:0] len, input logic [ByteW-1:0] val,
                                input logic mark);
    if (len == 8'd1) begin
      if (val == 8'h00) begin
        exp_codes.push_back('{code: 8'h00, last: 1'b0});
        escaped_zeros++;
      end
      exp_codes.push_back('{code: val, last: mark});
    end else begin
      exp_codes.push_back('{code: 8'h00, last: 1'b0});
      exp_codes.push_back('{code: len, last: 1'b0});
      exp_codes.push_back('{code: val, last: mark});
    end
  endtask

  // Advance the encoder state by one raw byte and queue what it emits.
  task automatic encode_byte(input logic [ByteW-1:0] raw, input logic eos);
    logic [ByteW-1:0] delta;
    delta = raw - last_raw;
    last_raw = raw;
    if (open_len == 8'd0) begin
      open_delta = delta;
      open_len = 8'd1;
    end else if (delta == open_delta && open_len < MAX_RUN) begin
      open_len = open_len + 8'd1;
    end else begin
      if (delta == open_delta) full_runs++;
      emit_run_codes(open_len, open_delta, 1'b0);
      open_delta = delta;
      open_len = 8'd1;
    end
    if (eos) begin
      emit_run_codes(open_len, open_delta, 1'b1);
      last_raw = '0;
      open_delta = '0;
      open_len = '0;
      streams_done++;
    end
  endtask

  // Offer one raw byte and wait until the encoder takes it. push stays high
  // into the next call when no gap follows.
  task automatic push_byte(input logic [ByteW-1:0] raw, input logic eos);
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    if (!push) push <= 1'b1;
    data_byte <= raw;
    end_of_stream <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_byte(raw, eos);
    bytes_sent++;
    next_gap = steady_in ? 0 : pick_gap();
    if (next_gap > 0) push <= 1'b0;
  endtask

  // Stop offering bytes, in the same step as the last accepted beat.
  task automatic end_burst();
    if (next_gap == 0) push <= 1'b0;
    next_gap = 0;
  endtask

  // Wait until every expected code byte has been popped.
  task automatic drain_codes();
    @(posedge clk_i);
    while (exp_codes.size() != 0) @(posedge clk_i);
  endtask

  // Streams of one byte: lone zero, lone extremes.
  task automatic test_single_byte_streams();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b1);
    end_burst();
    drain_codes();
  endtask

  // Every run form, and a run closing on the same byte that ends the stream.
  task automatic test_run_forms();
    // Lone nonzero, lone zero, run of three, lone zero, run flushed at the end.
    push_byte(8'h05, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'h14, 1'b0);
    push_byte(8'h14, 1'b0);
    push_byte(8'h13, 1'b0);
    push_byte(8'h12, 1'b1);
    // A run of zero deltas flushed by the end.
    push_byte(8'h07, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'h07, 1'b1);
    // A run closed by a lone zero that also ends the stream.
    push_byte(8'h0A, 1'b0);
    push_byte(8'h14, 1'b0);
    push_byte(8'h1E, 1'b0);
    push_byte(8'h1E, 1'b1);
    // Wrapping deltas; a run closed by a lone nonzero that ends the stream.
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h7F, 1'b1);
    end_burst();
    drain_codes();
  endtask

  // A run that reaches the longest length and is cut by the byte that also
  // ends the stream.
  task automatic test_full_runs();
    logic [ByteW-1:0] raw;
    logic [ByteW-1:0] step;
    step = 8'($urandom_range(255, 1));
    raw = '0;
    for (int i = 0; i <= MAX_RUN; i++) begin
      raw = raw + step;
      push_byte(raw, i == MAX_RUN);
    end
    end_burst();
    drain_codes();
  endtask

  // Deltas biased toward zero and the wrap points.
  function automatic logic [ByteW-1:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'h00;
    if (r < 36) return 8'hFF;
    if (r < 40) return 8'h01;
    if (r < 43) return 8'h80;
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(199);
    if (r < 100) return 1;
    if (r < 160) return $urandom_range(4, 2);
    if (r < 198) return $urandom_range(20, 5);
    return $urandom_range(40, 21);
  endfunction

  // Streams built from runs of random deltas, with some streams of noise.
  task automatic test_random_streams();
    int start_count;
    int n_runs;
    int run_len;
    int noise_len;
    logic [ByteW-1:0] raw;
    logic [ByteW-1:0] delta;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      steady_in = ($urandom_range(4) == 0);
      steady_out = ($urandom_range(4) == 0);
      if ($urandom_range(7) == 0) begin
        noise_len = $urandom_range(12, 1);
        for (int i = 0; i < noise_len; i++) begin
          push_byte(8'($urandom_range(255)), i == noise_len - 1);
        end
      end else begin
        n_runs = $urandom_range(8, 1);
        raw = '0;
        for (int r = 0; r < n_runs; r++) begin
          delta = pick_delta();
          run_len = pick_run_len();
          for (int k = 0; k < run_len; k++) begin
            raw = raw + delta;
            push_byte(raw, (r == n_runs - 1) && (k == run_len - 1));
          end
        end
      end
    end
    steady_in = 1'b0;
    steady_out = 1'b0;
    end_burst();
    drain_codes();
  endtask

  // Pop side: random stalls, and every popped beat compared with the oldest
  // expected code byte.
  initial begin
    code_beat_t exp_beat;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (exp_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected code beat: byte %02h last %0b", code_byte, code_last);
          end
        end else begin
          exp_beat = exp_codes.pop_front();
          codes_seen++;
          if (code_byte !== exp_beat.code || code_last !== exp_beat.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Code beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       codes_seen, exp_beat.code, exp_beat.last, code_byte, code_last);
            end
          end
        end
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_wait = steady_out ? 0 : pick_gap();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d code bytes outstanding.",
               cycles, exp_codes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_byte_streams();
    test_run_forms();
    test_full_runs();
    test_random_streams();
    repeat (20) @(posedge clk_i);
    $display("Encoded %0d raw bytes in %0d streams into %0d checked code bytes.",
             bytes_sent, streams_done, codes_seen);
    $display("Runs cut at full length: %0d; escaped lone zeros: %0d; mismatches: %0d.",
             full_runs, escaped_zeros, mismatches);
    if (mismatches == 0 && exp_codes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
